[src/false_position_root_finder_macros.svh]
// Assertion macros shared by the root finder RTL.
`ifndef FALSE_POSITION_ROOT_FINDER_MACROS_SVH
`define FALSE_POSITION_ROOT_FINDER_MACROS_SVH

// Same-cycle implication, clocked on clk, disabled in reset.
`define FPR_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk, disabled in reset.
`define FPR_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/fpr_pkg.sv]
// Types, constants and helpers for the false position root finder.
`default_nettype none
package fpr_pkg;

  localparam int unsigned DEF_VALUE_WIDTH   = 32;
  localparam int unsigned DEF_FRACTION_BITS = 16;

  localparam logic [30:0] ERR_MAX      = 31'h7FFF_FFFF;
  localparam logic [30:0] THRESH_RESET = 31'd655;
  localparam logic [15:0] LIMIT_RESET  = 16'd50;
  localparam logic signed [63:0] F_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;

  localparam logic REG_THRESHOLD = 1'b0;
  localparam logic REG_LIMIT     = 1'b1;

  typedef struct packed {
    logic signed [31:0] lower_bound;
    logic signed [31:0] upper_bound;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] root;
    logic [30:0]        error_pct;
    logic [16:0]        iterations;
    logic [1:0]         status;
  } out_word_t;

  typedef enum logic [1:0] {
    ST_CONVERGED, ST_LIMIT, ST_EXACT, ST_ZERO_DIV
  } status_t;

  typedef enum logic {OP_MUL, OP_DIV} arith_op_t;

  typedef struct packed {
    logic      go;
    arith_op_t op;
  } arith_req_t;

  typedef enum logic [3:0] {
    S_IDLE, S_SQ, S_SQ_W, S_CU, S_CU_W, S_ITER, S_CORR_W, S_CDIV_W,
    S_ERR_W, S_EDIV_W, S_UPDATE, S_DONE
  } state_t;

  typedef enum logic [1:0] {FT_L, FT_U, FT_R} ftarget_t;

  function automatic logic [63:0] mag64(input logic signed [63:0] v);
    mag64 = v[63] ? 64'(-v) : 64'(v);
  endfunction

  function automatic logic signed [63:0] sub_sat(input logic signed [63:0] a,
                                                 input logic signed [63:0] b);
    logic signed [64:0] d;
    d = 65'(a) - 65'(b);
    if (d > 65'(F_MAX))       sub_sat = F_MAX;
    else if (d < -65'(F_MAX)) sub_sat = -F_MAX;
    else                      sub_sat = d[63:0];
  endfunction

  function automatic logic signed [63:0] halve(input logic signed [63:0] v);
    logic signed [63:0] t;
    t = v + 64'({63'd0, v[63]});
    halve = t >>> 1;
  endfunction

endpackage
`default_nettype wire

[src/false_position_root_finder.sv]
// Top level of the modified false position root finder for f(x) = x^3 - x^2.
`default_nettype none
`include "false_position_root_finder_macros.svh"
// Raise start with a bracket on in_word while busy is low; busy then stays
// high until the result word has gone. The result is shown on out_word for
// exactly one cycle with out_valid high; there is no way to hold it off, so
// capture it on that cycle. Every multiply and divide runs on one shared unit.
// A 64x64 multiply takes 8 byte steps and a 128/64 divide takes 64 bit
// steps. An iteration runs 4 multiplies and 2 divides plus its control
// states. A zero estimate skips the error multiply and divide. A zero
// divisor ends the job with no multiply or divide. Setup evaluates f at
// both ends, and the result state S_DONE follows the last iteration. A job
// runs up to iteration_limit + 1 iterations. It ends early on convergence
// or a zero divisor.
// Write cfg registers only while busy is low.
module false_position_root_finder #(
  parameter int unsigned VALUE_WIDTH   = fpr_pkg::DEF_VALUE_WIDTH,
  parameter int unsigned FRACTION_BITS = fpr_pkg::DEF_FRACTION_BITS
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  output logic                   busy,
  input  wire fpr_pkg::in_word_t in_word,
  output logic                   out_valid,
  output fpr_pkg::out_word_t     out_word,
  input  wire logic              cfg_we,
  input  wire logic              cfg_index,
  input  wire logic [30:0]       cfg_data
);
  import fpr_pkg::*;

  localparam logic signed [63:0] VMAX = (64'sd1 <<< (VALUE_WIDTH - 1)) - 64'sd1;
  localparam logic signed [63:0] VMIN = -VMAX - 64'sd1;
  localparam logic [63:0] PCT_SCALE = 64'd100 << FRACTION_BITS;
  localparam logic [63:0] CORR_MAX  = 64'd1 << 62;
  localparam logic [31:0] ROOT_MASK =
    (VALUE_WIDTH >= 32) ? 32'hFFFF_FFFF : 32'((64'd1 << VALUE_WIDTH) - 64'd1);

  // sign-extend an input field from VALUE_WIDTH bits
  function automatic logic signed [63:0] sext_in(input logic [31:0] raw);
    logic [63:0]            w;
    logic [VALUE_WIDTH-1:0] lo;
    w  = {32'd0, raw};
    lo = w[VALUE_WIDTH-1:0];
    sext_in = {{(64 - VALUE_WIDTH){lo[VALUE_WIDTH-1]}}, lo};
  endfunction

  // fractional product: drop fraction bits, saturate, apply sign
  function automatic logic signed [63:0] mulq(input logic [127:0] p, input logic neg);
    logic [127:0] sh;
    logic [63:0]  m;
    sh = p >> FRACTION_BITS;
    m  = (|sh[127:63]) ? 64'(F_MAX) : {1'b0, sh[62:0]};
    mulq = neg ? -$signed(m) : $signed(m);
  endfunction

  state_t   state_r, state_nxt;
  ftarget_t ftgt_r, ftgt_nxt;
  logic signed [63:0] xl_r, xl_nxt, xu_r, xu_nxt, xr_r, xr_nxt, xold_r, xold_nxt;
  logic signed [63:0] fl_r, fl_nxt, fu_r, fu_nxt, fr_r, fr_nxt, den_r, den_nxt;
  logic signed [63:0] fx_r, fx_nxt, x2_r, x2_nxt;
  logic        sl_neg_r, sl_neg_nxt, sl_zero_r, sl_zero_nxt;
  logic        cneg_r, cneg_nxt, exact_r, exact_nxt, zdiv_r, zdiv_nxt;
  logic [30:0] ea_r, ea_nxt, thr_r;
  logic [16:0] iter_r, iter_nxt;
  logic [15:0] lim_r;
  logic [1:0]  il_r, il_nxt, iu_r, iu_nxt;

  arith_req_t   req;
  logic [63:0]  ar_a, ar_b;
  logic         ar_done, ar_over;
  logic [127:0] ar_acc;

  logic signed [63:0] den_c, dlx_c, f_c, q_c, xr_c, v_c;
  logic [63:0]        quo_c, qmag_c;
  logic [1:0]         il_inc, iu_inc;
  logic               fr_pos, fr_neg, tneg, tpos;

  fpr_arith u_arith (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (req),
    .a    (ar_a),
    .b    (ar_b),
    .done (ar_done),
    .acc  (ar_acc),
    .over (ar_over)
  );

  assign den_c  = sub_sat(fl_r, fu_r);
  assign dlx_c  = xl_r - xu_r;
  assign f_c    = sub_sat(mulq(ar_acc, fx_r[63]), x2_r);
  assign quo_c  = ar_over ? 64'hFFFF_FFFF_FFFF_FFFF : ar_acc[63:0];
  assign qmag_c = (quo_c > CORR_MAX) ? CORR_MAX : quo_c;
  assign q_c    = cneg_r ? -$signed(qmag_c) : $signed(qmag_c);
  assign v_c    = xu_r - q_c;
  assign xr_c   = (v_c > VMAX) ? VMAX : ((v_c < VMIN) ? VMIN : v_c);
  assign fr_pos = !fr_r[63] && (fr_r != 64'sd0);
  assign fr_neg = fr_r[63];
  // product of signs: sign of f at the kept lower end times sign of f(xr)
  assign tneg   = (sl_neg_r && fr_pos) || (!sl_neg_r && !sl_zero_r && fr_neg);
  assign tpos   = (sl_neg_r && fr_neg) || (!sl_neg_r && !sl_zero_r && fr_pos);
  assign il_inc = (il_r < 2'd2) ? il_r + 2'd1 : il_r;
  assign iu_inc = (iu_r < 2'd2) ? iu_r + 2'd1 : iu_r;

  always_comb begin
    state_nxt   = state_r;
    ftgt_nxt    = ftgt_r;
    xl_nxt      = xl_r;
    xu_nxt      = xu_r;
    xr_nxt      = xr_r;
    xold_nxt    = xold_r;
    fl_nxt      = fl_r;
    fu_nxt      = fu_r;
    fr_nxt      = fr_r;
    den_nxt     = den_r;
    fx_nxt      = fx_r;
    x2_nxt      = x2_r;
    sl_neg_nxt  = sl_neg_r;
    sl_zero_nxt = sl_zero_r;
    cneg_nxt    = cneg_r;
    exact_nxt   = exact_r;
    zdiv_nxt    = zdiv_r;
    ea_nxt      = ea_r;
    iter_nxt    = iter_r;
    il_nxt      = il_r;
    iu_nxt      = iu_r;
    req.go      = 1'b0;
    req.op      = OP_MUL;
    ar_a        = '0;
    ar_b        = '0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          xl_nxt    = sext_in(in_word.lower_bound);
          xu_nxt    = sext_in(in_word.upper_bound);
          xr_nxt    = sext_in(in_word.lower_bound);
          fx_nxt    = sext_in(in_word.lower_bound);
          ea_nxt    = ERR_MAX;
          iter_nxt  = '0;
          il_nxt    = '0;
          iu_nxt    = '0;
          exact_nxt = 1'b0;
          zdiv_nxt  = 1'b0;
          ftgt_nxt  = FT_L;
          state_nxt = S_SQ;
        end
      end
      S_SQ: begin
        // square the argument
        req.go    = 1'b1;
        ar_a      = mag64(fx_r);
        ar_b      = mag64(fx_r);
        state_nxt = S_SQ_W;
      end
      S_SQ_W: begin
        if (ar_done) begin
          x2_nxt    = mulq(ar_acc, 1'b0);
          state_nxt = S_CU;
        end
      end
      S_CU: begin
        req.go    = 1'b1;
        ar_a      = mag64(x2_r);
        ar_b      = mag64(fx_r);
        state_nxt = S_CU_W;
      end
      S_CU_W: begin
        if (ar_done) begin
          case (ftgt_r)
            FT_L: begin
              fl_nxt      = f_c;
              sl_neg_nxt  = f_c[63];
              sl_zero_nxt = (f_c == 64'sd0);
              fx_nxt      = xu_r;
              ftgt_nxt    = FT_U;
              state_nxt   = S_SQ;
            end
            FT_U: begin
              fu_nxt    = f_c;
              state_nxt = S_ITER;
            end
            default: begin
              fr_nxt    = f_c;
              state_nxt = S_UPDATE;
            end
          endcase
        end
      end
      S_ITER: begin
        iter_nxt = iter_r + 17'd1;
        if (den_c == 64'sd0) begin
          zdiv_nxt  = 1'b1;
          state_nxt = S_DONE;
        end else begin
          // correction numerator |fu| * |xl - xu|
          req.go    = 1'b1;
          ar_a      = mag64(fu_r);
          ar_b      = mag64(dlx_c);
          den_nxt   = den_c;
          cneg_nxt  = (fu_r[63] ^ dlx_c[63]) ^ den_c[63];
          xold_nxt  = xr_r;
          state_nxt = S_CORR_W;
        end
      end
      S_CORR_W: begin
        if (ar_done) begin
          req.go    = 1'b1;
          req.op    = OP_DIV;
          ar_b      = mag64(den_r);
          state_nxt = S_CDIV_W;
        end
      end
      S_CDIV_W: begin
        if (ar_done) begin
          xr_nxt   = xr_c;
          fx_nxt   = xr_c;
          ftgt_nxt = FT_R;
          if (xr_c != 64'sd0) begin
            req.go    = 1'b1;
            ar_a      = mag64(xr_c - xold_r);
            ar_b      = PCT_SCALE;
            state_nxt = S_ERR_W;
          end else begin
            // zero estimate: keep the previous error
            state_nxt = S_SQ;
          end
        end
      end
      S_ERR_W: begin
        if (ar_done) begin
          req.go    = 1'b1;
          req.op    = OP_DIV;
          ar_b      = mag64(xr_r);
          state_nxt = S_EDIV_W;
        end
      end
      S_EDIV_W: begin
        if (ar_done) begin
          ea_nxt    = (quo_c > 64'(ERR_MAX)) ? ERR_MAX : quo_c[30:0];
          state_nxt = S_SQ;
        end
      end
      S_UPDATE: begin
        exact_nxt = 1'b0;
        if (tneg) begin
          xu_nxt = xr_r;
          fu_nxt = fr_r;
          iu_nxt = '0;
          il_nxt = il_inc;
          if (il_inc >= 2'd2) fl_nxt = halve(fl_r);
        end else if (tpos) begin
          xl_nxt      = xr_r;
          fl_nxt      = fr_r;
          sl_neg_nxt  = fr_neg;
          sl_zero_nxt = 1'b0;
          il_nxt      = '0;
          iu_nxt      = iu_inc;
          if (iu_inc >= 2'd2) fu_nxt = halve(fu_r);
        end else begin
          ea_nxt    = '0;
          exact_nxt = 1'b1;
        end
        if ((ea_nxt >= thr_r) && (iter_r <= {1'b0, lim_r})) state_nxt = S_ITER;
        else state_nxt = S_DONE;
      end
      S_DONE: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control state and configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      thr_r   <= THRESH_RESET;
      lim_r   <= LIMIT_RESET;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        case (cfg_index)
          REG_THRESHOLD: thr_r <= cfg_data;
          REG_LIMIT:     lim_r <= cfg_data[15:0];
          default:       thr_r <= thr_r;
        endcase
      end
    end
  end

  // working values: payload, no reset
  always_ff @(posedge clk) begin
    ftgt_r    <= ftgt_nxt;
    xl_r      <= xl_nxt;
    xu_r      <= xu_nxt;
    xr_r      <= xr_nxt;
    xold_r    <= xold_nxt;
    fl_r      <= fl_nxt;
    fu_r      <= fu_nxt;
    fr_r      <= fr_nxt;
    den_r     <= den_nxt;
    fx_r      <= fx_nxt;
    x2_r      <= x2_nxt;
    sl_neg_r  <= sl_neg_nxt;
    sl_zero_r <= sl_zero_nxt;
    cneg_r    <= cneg_nxt;
    exact_r   <= exact_nxt;
    zdiv_r    <= zdiv_nxt;
    ea_r      <= ea_nxt;
    iter_r    <= iter_nxt;
    il_r      <= il_nxt;
    iu_r      <= iu_nxt;
  end

  assign busy               = (state_r != S_IDLE);
  assign out_valid          = (state_r == S_DONE);
  assign out_word.root      = xr_r[31:0] & ROOT_MASK;
  assign out_word.error_pct = ea_r;
  assign out_word.iterations = iter_r;
  always_comb begin
    if (zdiv_r)             out_word.status = ST_ZERO_DIV;
    else if (exact_r)       out_word.status = ST_EXACT;
    else if (ea_r < thr_r)  out_word.status = ST_CONVERGED;
    else                    out_word.status = ST_LIMIT;
  end

  `FPR_ASSERT_NXT(a_start_busy, start && !busy, busy, "accepted word did not raise busy")
  `FPR_ASSERT_NXT(a_single_strobe, out_valid, !out_valid, "result strobe longer than one cycle")
  `FPR_ASSERT_IMP(a_iter_count, out_valid, out_word.iterations != 17'd0, "result with no iteration")
  `FPR_ASSERT_IMP(a_conv_err, out_valid && (out_word.status == ST_CONVERGED), out_word.error_pct < thr_r, "converged above threshold")

endmodule
`default_nettype wire

[src/fpr_arith.sv]
// Shared multiply and divide unit: 64x64 multiply, 128/64 saturating divide.
`default_nettype none
module fpr_arith (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire fpr_pkg::arith_req_t req,
  input  wire logic [63:0]        a,
  input  wire logic [63:0]        b,
  output logic                    done,
  output logic [127:0]            acc,
  output logic                    over
);
  import fpr_pkg::*;

  logic [127:0] acc_r, acc_nxt;
  logic [63:0]  a_r, d_r;
  logic [5:0]   cnt_r;
  logic         busy_r, done_r, over_r;
  arith_op_t    op_r;
  logic [71:0]  msum;
  logic [64:0]  rem, diff;

  assign msum = {8'd0, acc_r[127:64]} + 72'(a_r) * 72'(acc_r[7:0]);
  assign rem  = {acc_r[127:64], acc_r[63]};
  assign diff = rem - {1'b0, d_r};

  always_comb begin
    if (op_r == OP_MUL) begin
      acc_nxt = {msum, acc_r[63:8]};
    end else if (rem >= {1'b0, d_r}) begin
      acc_nxt = {diff[63:0], acc_r[62:0], 1'b1};
    end else begin
      acc_nxt = {rem[63:0], acc_r[62:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && (cnt_r == 6'd0);
      if (req.go) begin
        busy_r <= 1'b1;
        cnt_r  <= (req.op == OP_MUL) ? 6'd7 : 6'd63;
      end else if (busy_r) begin
        if (cnt_r == 6'd0) busy_r <= 1'b0;
        cnt_r <= cnt_r - 6'd1;
      end
    end
  end

  // operands and accumulator: payload, no reset
  always_ff @(posedge clk) begin
    if (req.go) begin
      op_r <= req.op;
      if (req.op == OP_MUL) begin
        a_r   <= a;
        acc_r <= {64'd0, b};
      end else begin
        d_r    <= b;
        over_r <= acc_r[127:64] >= b;
      end
    end else if (busy_r) begin
      acc_r <= acc_nxt;
    end
  end

  assign done = done_r;
  assign acc  = acc_r;
  assign over = over_r;

endmodule
`default_nettype wire

[tb/sv/false_position_root_finder_checker.sv]
// Checker for the root finder: predicts each result word and compares it.
`default_nettype none
module false_position_root_finder_checker (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire logic               busy,
  input  wire fpr_pkg::in_word_t  in_word,
  input  wire logic               out_valid,
  input  wire fpr_pkg::out_word_t out_word,
  input  wire logic               cfg_we,
  input  wire logic               cfg_index,
  input  wire logic [30:0]        cfg_data,
  output int                      failures,
  output int                      pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import fpr_pkg::*;

  localparam logic [63:0] SAT_POS  = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] CORR_MAX = 64'h4000_0000_0000_0000;

  logic [30:0] threshold;
  logic [15:0] limit;
  out_word_t   roots_q[$];

  function automatic logic [63:0] magnitude(input logic signed [63:0] v);
    return v[63] ? 64'(-v) : 64'(v);
  endfunction

  function automatic logic [63:0] quot_clamp(input logic [127:0] n, input logic [63:0] d);
    logic [127:0] q;
    q = n / {64'd0, d};
    return (q[127:64] != 0) ? '1 : q[63:0];
  endfunction

  function automatic logic signed [63:0] fix_mul(input logic signed [63:0] a,
                                                 input logic signed [63:0] b);
    logic [127:0] p;
    logic [63:0]  m;
    p = ({64'd0, magnitude(a)} * {64'd0, magnitude(b)}) >> 16;
    m = (p[127:64] != 0) ? '1 : p[63:0];
    if (m > SAT_POS) m = SAT_POS;
    return (a[63] != b[63]) ? -$signed(m) : $signed(m);
  endfunction

  function automatic logic signed [63:0] clamp_sub(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
    logic signed [64:0] d;
    d = 65'(a) - 65'(b);
    if (d > $signed({1'b0, SAT_POS})) return SAT_POS;
    if (d < -$signed({1'b0, SAT_POS})) return -$signed(SAT_POS);
    return d[63:0];
  endfunction

  // f(x) = x^3 - x^2 in Q48.16
  function automatic logic signed [63:0] cubic(input logic signed [63:0] x);
    logic signed [63:0] x2;
    x2 = fix_mul(x, x);
    return clamp_sub(fix_mul(x2, x), x2);
  endfunction

  function automatic int sign_of(input logic signed [63:0] v);
    return (v > 0) ? 1 : ((v < 0) ? -1 : 0);
  endfunction

  function automatic out_word_t find_root(input in_word_t w, input logic [30:0] thr,
                                          input logic [15:0] lim);
    logic signed [63:0] xl, xu, xr, xold, fl, fu, fr, den, d, q, v;
    logic [63:0] qm, e;
    logic [31:0] ea;
    int unsigned iter;
    int il, iu, t;
    bit exact, zdiv, running, neg;
    out_word_t r;
    xl = 64'(w.lower_bound);
    xu = 64'(w.upper_bound);
    xr = xl;
    fl = cubic(xl);
    fu = cubic(xu);
    ea = {1'b0, ERR_MAX};
    iter = 0; il = 0; iu = 0;
    exact = 0; zdiv = 0; running = 1;
    while (running) begin
      xold = xr;
      iter++;
      den = clamp_sub(fl, fu);
      if (den == 0) begin
        zdiv = 1;
        running = 0;
      end else begin
        d = xl - xu;
        qm = quot_clamp({64'd0, magnitude(fu)} * {64'd0, magnitude(d)}, magnitude(den));
        neg = (fu[63] != d[63]) != den[63];
        if (qm > CORR_MAX) qm = CORR_MAX;
        q = neg ? -$signed(qm) : $signed(qm);
        v = xu - q;
        if (v > 64'sh7FFF_FFFF) xr = 64'sh7FFF_FFFF;
        else if (v < -64'sh8000_0000) xr = -64'sh8000_0000;
        else xr = v;
        // a zero estimate keeps the previous error
        if (xr != 0) begin
          e = quot_clamp({64'd0, magnitude(xr - xold)} * 128'(64'd100 << 16), magnitude(xr));
          ea = (e > 64'(ERR_MAX)) ? {1'b0, ERR_MAX} : e[31:0];
        end
        fr = cubic(xr);
        t = sign_of(cubic(xl)) * sign_of(fr);
        exact = 0;
        if (t < 0) begin
          xu = xr; fu = fr; iu = 0;
          if (il < 2) il++;
          if (il >= 2) fl = fl / 64'sd2;
        end else if (t > 0) begin
          xl = xr; fl = fr; il = 0;
          if (iu < 2) iu++;
          if (iu >= 2) fu = fu / 64'sd2;
        end else begin
          ea = 0;
          exact = 1;
        end
        running = (ea >= 32'(thr)) && (iter <= lim);
      end
    end
    r.root       = xr[31:0];
    r.error_pct  = ea[30:0];
    r.iterations = iter[16:0];
    if (zdiv) r.status = ST_ZERO_DIV;
    else if (exact) r.status = ST_EXACT;
    else if (ea < 32'(thr)) r.status = ST_CONVERGED;
    else r.status = ST_LIMIT;
    return r;
  endfunction

  always @(posedge clk) begin
    out_word_t exp_w;
    if (!rst_n) begin
      threshold <= THRESH_RESET;
      limit     <= LIMIT_RESET;
      failures  <= 0;
      pending   <= 0;
      roots_q.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_THRESHOLD) threshold <= cfg_data;
        else limit <= cfg_data[15:0];
      end
      if (start && !busy) roots_q.push_back(find_root(in_word, threshold, limit));
      if (out_valid) begin
        if (roots_q.size() == 0) begin
          $error("result word with nothing expected");
          failures <= failures + 1;
        end else begin
          exp_w = roots_q.pop_front();
          if (out_word != exp_w) begin
            failures <= failures + 1;
            if (out_word.root != exp_w.root)
              $error("root: expected %0d, got %0d", exp_w.root, out_word.root);
            if (out_word.error_pct != exp_w.error_pct)
              $error("error_pct: expected %0d, got %0d", exp_w.error_pct, out_word.error_pct);
            if (out_word.iterations != exp_w.iterations)
              $error("iterations: expected %0d, got %0d", exp_w.iterations,
                     out_word.iterations);
            if (out_word.status != exp_w.status)
              $error("status: expected %0d, got %0d", exp_w.status, out_word.status);
          end
        end
      end
      pending <= roots_q.size();
    end
  end
endmodule
`default_nettype wire

[tb/sv/false_position_root_finder_tb.sv]
// Top of the root finder testbench: stimulus, configuration and verdict.
`default_nettype none
module false_position_root_finder_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import fpr_pkg::*;

  localparam int          MAX_CYCLES = 6_000_000;
  localparam logic [31:0] ONE        = 32'h0001_0000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  in_word_t    in_word = '0;
  logic        out_valid;
  out_word_t   out_word;
  logic        cfg_we = 1'b0;
  logic        cfg_index = REG_THRESHOLD;
  logic [30:0] cfg_data = '0;
  int          failures, pending;
  int          cycles = 0;
  bit          quiet = 0;

  // 8 ns period
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  false_position_root_finder dut (
    .clk, .rst_n, .start, .busy, .in_word, .out_valid, .out_word,
    .cfg_we, .cfg_index, .cfg_data
  );

  false_position_root_finder_checker checker_i (
    .clk, .rst_n, .start, .busy, .in_word, .out_valid, .out_word,
    .cfg_we, .cfg_index, .cfg_data, .failures, .pending
  );

  // Give up if the block hangs.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > MAX_CYCLES) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Present one bracket at a falling edge and hold it until taken. Afterwards
  // maybe drop start for a burst of idle cycles; otherwise keep it high so the
  // next word follows back to back.
  task automatic send_bracket(input logic [31:0] lo, input logic [31:0] up);
    int gap;
    start <= 1'b1;
    in_word <= '{lower_bound: lo, upper_bound: up};
    do @(posedge clk); while (busy);
    @(negedge clk);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 18);
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  // Hold off until every word expected has come back and the block is idle.
  task automatic drain;
    start <= 1'b0;
    @(negedge clk);
    while (pending != 0 || busy) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [30:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Mostly brackets around the root at 1.0, the rest raw noise.
  task automatic random_bracket;
    if ($urandom_range(0, 3) != 0)
      send_bracket($urandom_range(0, 65535), 32'd65537 + $urandom_range(0, 3 * 65536));
    else
      send_bracket($urandom, $urandom);
  endtask

  initial begin
    logic [30:0] thr;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: reset configuration first.
    send_bracket(ONE >> 1, ONE + (ONE >> 1));          // clean bracket round 1.0
    send_bracket(ONE, 2 * ONE);                        // lands on the root exactly
    send_bracket(0, 2 * ONE);                          // estimate becomes zero
    send_bracket(3 * ONE, 3 * ONE);                    // equal ends: zero divisor
    send_bracket(2 * ONE, ONE >> 1);                   // reversed
    send_bracket(2 * ONE, 3 * ONE);                    // not bracketing
    send_bracket(32'h8000_0000, 32'h7FFF_FFFF);        // full range
    send_bracket(32'h7FFF_FFFF, 32'h8000_0000);
    send_bracket(32'hFFFF_FFFF, 32'h0000_0001);
    send_bracket(-2 * ONE, ONE >> 2);
    drain();

    // Extremes of the registers.
    write_reg(REG_THRESHOLD, '0);
    write_reg(REG_LIMIT, 31'd1);
    send_bracket(ONE >> 1, 2 * ONE);
    send_bracket(32'h8000_0000, 32'h8000_0000);
    drain();
    write_reg(REG_LIMIT, 31'd0);
    send_bracket(ONE >> 1, 2 * ONE);
    drain();
    write_reg(REG_THRESHOLD, 31'h7FFF_FFFF);
    write_reg(REG_LIMIT, 31'h7FFF_FFFF);               // low 16 bits give 65535
    send_bracket(ONE >> 1, 2 * ONE);
    send_bracket(5 * ONE, 5 * ONE);
    drain();
    write_reg(REG_THRESHOLD, 31'd655);
    send_bracket(ONE >> 2, ONE + (ONE >> 3));
    send_bracket(ONE, 2 * ONE);
    drain();

    // Random phases, each with its own setting, the last without idling.
    for (int ph = 0; ph < 6; ph++) begin
      case ($urandom_range(0, 3))
        0: thr = '0;
        1: thr = 31'h7FFF_FFFF;
        2: thr = 31'($urandom_range(1, 65536));
        default: thr = 31'($urandom);
      endcase
      if (ph == 5) begin
        quiet = 1;
        thr = 31'd655;
      end
      write_reg(REG_THRESHOLD, thr);
      write_reg(REG_LIMIT, 31'({$urandom, 16'd0}) | 31'($urandom_range(1, 16)));
      repeat (50) random_bracket();
      drain();
    end

    repeat (50) @(negedge clk);
    if (failures == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule
`default_nettype wire
